// ----- src/dual_kernel_conv3x3_clamp_top_defines.svh -----
// Assertion macros for the two-kernel 3x3 filter.
`ifndef DUAL_KERNEL_CONV3X3_CLAMP_TOP_DEFINES_SVH
`define DUAL_KERNEL_CONV3X3_CLAMP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DKC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dkc assertion failed");
`define DKC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dkc assertion failed");
`else
`define DKC_ASSERT_IMP(label, ante, cons)
`define DKC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- src/dkc_pkg.sv -----
package dkc_pkg;

    localparam int MAX_SIZE = 1024;
    localparam int MIN_SIZE = 2;
    localparam int IMG_W = 11;
    localparam int SIZE_W = ($clog2(MAX_SIZE + 1) > IMG_W) ? $clog2(MAX_SIZE + 1) : IMG_W;
    localparam int ADDR_W = $clog2(MAX_SIZE);
    localparam int PIX_W = 8;
    localparam int KC_W = 8;
    localparam int ROW_W = 3 * KC_W;
    localparam int COEF_W = KC_W + 1;
    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int SUM_W = PROD_W + 4;
    localparam int REG_COUNT = 7;
    localparam int IDX_W = $clog2(REG_COUNT);
    localparam int OUTQ_PTR_W = 4;
    localparam int OUTQ_DEPTH = 1 << OUTQ_PTR_W;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [IDX_W-1:0] REG_IMAGE_SIZE = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_K1_TOP = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_K1_MIDDLE = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_K1_BOTTOM = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_K2_TOP = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_K2_MIDDLE = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_K2_BOTTOM = IDX_W'(6);

    localparam logic [IMG_W-1:0] IMAGE_SIZE_RESET = 11'd1024;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef logic [PIX_W-1:0] pix_t;
    // Index 0 is the top row, 2 the bottom row.
    typedef pix_t [2:0] column_t;
    // Index 0 is the left column, 2 the right column.
    typedef column_t [2:0] window_t;
    typedef logic [2:0][2:0][COEF_W-1:0] coefs_t;

    typedef struct packed {
        logic    valid;
        logic    two;
        logic    eoi;
        window_t first;
        window_t second;
    } req_t;

    typedef struct packed {
        logic              valid;
        logic              two;
        logic              eoi;
        logic [SUM_W-1:0]  sum0;
        logic [SUM_W-1:0]  sum1;
    } acc_t;

    typedef struct packed {
        logic p_valid;
        logic s_valid;
    } mac_busy_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [IMG_W-1:0] size);
        logic [SIZE_W-1:0] n;
        n = SIZE_W'(size);
        if (n < SIZE_W'(MIN_SIZE))
        begin
            n = SIZE_W'(MIN_SIZE);
        end
        else if (n > SIZE_W'(MAX_SIZE))
        begin
            n = SIZE_W'(MAX_SIZE);
        end
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] clamp_addr(input logic [SIZE_W-1:0] v);
        return (v >= SIZE_W'(MAX_SIZE)) ? ADDR_W'(MAX_SIZE - 1) : v[ADDR_W-1:0];
    endfunction

endpackage

// ----- src/dual_kernel_conv3x3_clamp_top.sv -----
// Streaming 3x3 filter that adds two signed kernels, takes the absolute
// value and clamps it to 0..255, for square images in raster order.
// The item channel takes one command and pixel per request: pixel requests
// carry the image, and after the last pixel one drain request per column
// yields the bottom row. The result channel gives pixel_out with
// last_of_item and end_of_image. Both channels use valid and stall.
// The configuration channel writes one register per request with cfg_index
// and cfg_data; cfg_ready is always high. The user must make writes go in
// only while idle; the block does not enforce it. One item is taken per
// cycle while item_stall is low. A request passes the front registers,
// multiplier stage, adder stage and queue write; a row end's two results
// are queued together. Results wait in a 16-entry queue, and item_stall
// rises when the queue together with the requests still in the pipeline
// could fill it. Reset empties the queue and pipeline, zeroes the counters
// and window, sets the size to 1024 and clears the kernels. The line
// stores are not cleared; every location is written before it is used.
`include "dual_kernel_conv3x3_clamp_top_defines.svh"

module dual_kernel_conv3x3_clamp_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        command,
    input  dkc_pkg::pix_t               pixel_in,
    output logic                        result_valid,
    input  logic                        result_stall,
    output dkc_pkg::pix_t               pixel_out,
    output logic                        last_of_item,
    output logic                        end_of_image,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dkc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [dkc_pkg::ROW_W-1:0]   cfg_data
);
    import dkc_pkg::*;

    localparam int RES_W = OUTQ_PTR_W + 3;

    logic [IMG_W-1:0]      image_size_reg;
    logic [ROW_W-1:0]      k1_reg [3];
    logic [ROW_W-1:0]      k2_reg [3];
    coefs_t                coef_reg, coef_next;

    logic                  accept;
    req_t                  req;
    acc_t                  acc;
    mac_busy_t             busy;
    logic [OUTQ_PTR_W:0]   queue_count;
    logic [1:0]            inflight;
    logic [RES_W-1:0]      reserved;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= IMAGE_SIZE_RESET;
            for (int i = 0; i < 3; i++)
            begin
                k1_reg[i] <= '0;
                k2_reg[i] <= '0;
            end
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_IMAGE_SIZE: image_size_reg <= cfg_data[IMG_W-1:0];
                    REG_K1_TOP:     k1_reg[0] <= cfg_data;
                    REG_K1_MIDDLE:  k1_reg[1] <= cfg_data;
                    REG_K1_BOTTOM:  k1_reg[2] <= cfg_data;
                    REG_K2_TOP:     k2_reg[0] <= cfg_data;
                    REG_K2_MIDDLE:  k2_reg[1] <= cfg_data;
                    REG_K2_BOTTOM:  k2_reg[2] <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                coef_next[i][j] = COEF_W'($signed(k1_reg[i][KC_W*j +: KC_W]))
                                + COEF_W'($signed(k2_reg[i][KC_W*j +: KC_W]));
            end
        end
    end

    always_comb
    begin
        inflight = 2'(req.valid) + 2'(busy.p_valid) + 2'(busy.s_valid);
        reserved = RES_W'(queue_count) + RES_W'({inflight, 1'b0});
        item_stall = reserved > RES_W'(OUTQ_DEPTH - 2);
        accept = item_valid && !item_stall;
    end

    dkc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (command),
        .pixel_in   (pixel_in),
        .image_size (image_size_reg),
        .req        (req)
    );

    dkc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .coefs (coef_reg),
        .acc   (acc),
        .busy  (busy)
    );

    dkc_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .pixel_out    (pixel_out),
        .last_of_item (last_of_item),
        .end_of_image (end_of_image),
        .count        (queue_count)
    );

    `DKC_ASSERT_IMP(a_queue_bound, 1'b1, queue_count <= (OUTQ_PTR_W + 1)'(OUTQ_DEPTH))
    `DKC_ASSERT_IMP(a_full_stalls, queue_count == (OUTQ_PTR_W + 1)'(OUTQ_DEPTH), item_stall)
    `DKC_ASSERT_IMP(a_eoi_last, result_valid && end_of_image, last_of_item)
    `DKC_ASSERT_NXT(a_queue_step, 1'b1, queue_count <= $past(queue_count) + (OUTQ_PTR_W + 1)'(2))

endmodule

// ----- src/dkc_ram.sv -----
module dkc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the new data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
        rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
    end

endmodule

// ----- src/dkc_front.sv -----
module dkc_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     command,
    input  dkc_pkg::pix_t            pixel_in,
    input  logic [dkc_pkg::IMG_W-1:0] image_size,
    output dkc_pkg::req_t            req
);
    import dkc_pkg::*;

    logic [SIZE_W-1:0] row_count_reg, row_count_next;
    logic [SIZE_W-1:0] column_count_reg, column_count_next;
    logic [SIZE_W-1:0] drain_count_reg, drain_count_next;

    logic [SIZE_W-1:0] n, n_m1, right_wide;
    logic [ADDR_W-1:0] col_addr, drain_addr, right_addr, rd_addr_a;
    logic              last_col, drain_end, take_pixel, take_drain, left_hit;

    logic              s1_pixel_act_reg, s1_drain_act_reg;
    pix_t              s1_pixel_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_row_ge2_reg, s1_col_ge2_reg, s1_result_reg, s1_last_reg;
    logic              s1_drain_ge1_reg, s1_end_reg;

    column_t           win_prev_reg, win_left_reg;
    pix_t              centre_older_reg, centre_newer_reg;

    pix_t              older_a, older_b, newer_a, newer_b;
    column_t           cur, left_col, d_left, d_centre, d_right;

    always_comb
    begin
        n = eff_size(image_size);
        n_m1 = n - SIZE_W'(1);
        col_addr = clamp_addr(column_count_reg);
        drain_addr = clamp_addr(drain_count_reg);
        last_col = SIZE_W'(col_addr) >= n_m1;
        drain_end = SIZE_W'(drain_addr) >= n_m1;
        right_wide = SIZE_W'(drain_addr) + SIZE_W'(1);
        right_addr = clamp_addr((right_wide < n) ? right_wide : SIZE_W'(drain_addr));
        take_pixel = accept && (command == CMD_PIXEL) && (row_count_reg < n);
        take_drain = accept && (command == CMD_DRAIN) && (row_count_reg >= n);
        rd_addr_a = (command == CMD_DRAIN) ? drain_addr : col_addr;
        left_hit = (drain_addr != '0) && (s1_addr_reg == drain_addr - ADDR_W'(1));

        row_count_next = row_count_reg;
        column_count_next = column_count_reg;
        drain_count_next = drain_count_reg;
        if (take_pixel)
        begin
            if (last_col)
            begin
                column_count_next = '0;
                row_count_next = row_count_reg + SIZE_W'(1);
            end
            else
            begin
                column_count_next = SIZE_W'(col_addr) + SIZE_W'(1);
            end
        end
        else if (take_drain)
        begin
            if (drain_end)
            begin
                row_count_next = '0;
                column_count_next = '0;
                drain_count_next = '0;
            end
            else
            begin
                drain_count_next = SIZE_W'(drain_addr) + SIZE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            column_count_reg <= '0;
            drain_count_reg <= '0;
            s1_pixel_act_reg <= 1'b0;
            s1_drain_act_reg <= 1'b0;
            win_prev_reg <= '0;
            win_left_reg <= '0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            column_count_reg <= column_count_next;
            drain_count_reg <= drain_count_next;
            s1_pixel_act_reg <= take_pixel;
            s1_drain_act_reg <= take_drain;
            if (s1_pixel_act_reg)
            begin
                win_left_reg <= win_prev_reg;
                win_prev_reg <= cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pixel_reg <= pixel_in;
        s1_addr_reg <= col_addr;
        s1_row_ge2_reg <= row_count_reg >= SIZE_W'(2);
        s1_col_ge2_reg <= col_addr >= ADDR_W'(2);
        s1_result_reg <= (row_count_reg != '0) && (col_addr != '0);
        s1_last_reg <= last_col;
        s1_drain_ge1_reg <= drain_addr != '0;
        s1_end_reg <= drain_end;
        if (s1_drain_act_reg)
        begin
            centre_older_reg <= older_a;
            centre_newer_reg <= newer_a;
        end
        // A pixel written to the column left of the next drain position
        // also refreshes the held copy of that column.
        else if (s1_pixel_act_reg && left_hit)
        begin
            centre_older_reg <= newer_a;
            centre_newer_reg <= s1_pixel_reg;
        end
    end

    dkc_ram #(
        .DEPTH (MAX_SIZE),
        .WIDTH (PIX_W)
    ) u_older (
        .clk     (clk),
        .we      (s1_pixel_act_reg),
        .waddr   (s1_addr_reg),
        .wdata   (newer_a),
        .raddr_a (rd_addr_a),
        .raddr_b (right_addr),
        .rdata_a (older_a),
        .rdata_b (older_b)
    );

    dkc_ram #(
        .DEPTH (MAX_SIZE),
        .WIDTH (PIX_W)
    ) u_newer (
        .clk     (clk),
        .we      (s1_pixel_act_reg),
        .waddr   (s1_addr_reg),
        .wdata   (s1_pixel_reg),
        .raddr_a (rd_addr_a),
        .raddr_b (right_addr),
        .rdata_a (newer_a),
        .rdata_b (newer_b)
    );

    always_comb
    begin
        cur[0] = s1_row_ge2_reg ? older_a : newer_a;
        cur[1] = newer_a;
        cur[2] = s1_pixel_reg;
        left_col = s1_col_ge2_reg ? win_left_reg : win_prev_reg;

        d_centre[0] = older_a;
        d_centre[1] = newer_a;
        d_centre[2] = newer_a;
        d_right[0] = older_b;
        d_right[1] = newer_b;
        d_right[2] = newer_b;
        if (s1_drain_ge1_reg)
        begin
            d_left[0] = centre_older_reg;
            d_left[1] = centre_newer_reg;
            d_left[2] = centre_newer_reg;
        end
        else
        begin
            d_left = d_centre;
        end

        req.valid = (s1_pixel_act_reg && s1_result_reg) || s1_drain_act_reg;
        req.two = s1_pixel_act_reg && s1_last_reg;
        req.eoi = s1_drain_act_reg && s1_end_reg;
        if (s1_drain_act_reg)
        begin
            req.first[0] = d_left;
            req.first[1] = d_centre;
            req.first[2] = d_right;
        end
        else
        begin
            req.first[0] = left_col;
            req.first[1] = win_prev_reg;
            req.first[2] = cur;
        end
        // The right edge repeats the last column.
        req.second[0] = win_prev_reg;
        req.second[1] = cur;
        req.second[2] = cur;
    end

endmodule

// ----- src/dkc_mac.sv -----
module dkc_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  dkc_pkg::req_t       req,
    input  dkc_pkg::coefs_t     coefs,
    output dkc_pkg::acc_t       acc,
    output dkc_pkg::mac_busy_t  busy
);
    import dkc_pkg::*;

    logic signed [PROD_W-1:0] prod0_next [3][3];
    logic signed [PROD_W-1:0] prod1_next [3][3];
    logic signed [PROD_W-1:0] prod0_reg [3][3];
    logic signed [PROD_W-1:0] prod1_reg [3][3];
    logic                     p_valid_reg, p_two_reg, p_eoi_reg;

    logic signed [SUM_W-1:0]  row0 [3];
    logic signed [SUM_W-1:0]  row1 [3];
    logic signed [SUM_W-1:0]  sum0_next, sum1_next, sum0_reg, sum1_reg;
    logic                     s_valid_reg, s_two_reg, s_eoi_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod0_next[i][j] = $signed(coefs[i][j]) * $signed({1'b0, req.first[j][i]});
                prod1_next[i][j] = $signed(coefs[i][j]) * $signed({1'b0, req.second[j][i]});
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            row0[i] = SUM_W'(prod0_reg[i][0]) + SUM_W'(prod0_reg[i][1])
                    + SUM_W'(prod0_reg[i][2]);
            row1[i] = SUM_W'(prod1_reg[i][0]) + SUM_W'(prod1_reg[i][1])
                    + SUM_W'(prod1_reg[i][2]);
        end
        sum0_next = row0[0] + row0[1] + row0[2];
        sum1_next = row1[0] + row1[1] + row1[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= req.valid;
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod0_reg <= prod0_next;
        prod1_reg <= prod1_next;
        p_two_reg <= req.two;
        p_eoi_reg <= req.eoi;
        sum0_reg <= sum0_next;
        sum1_reg <= sum1_next;
        s_two_reg <= p_two_reg;
        s_eoi_reg <= p_eoi_reg;
    end

    always_comb
    begin
        acc.valid = s_valid_reg;
        acc.two = s_two_reg;
        acc.eoi = s_eoi_reg;
        acc.sum0 = sum0_reg;
        acc.sum1 = sum1_reg;
        busy.p_valid = p_valid_reg;
        busy.s_valid = s_valid_reg;
    end

endmodule

// ----- src/dkc_outq.sv -----
module dkc_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dkc_pkg::acc_t                 acc,
    input  logic                          result_stall,
    output logic                          result_valid,
    output dkc_pkg::pix_t                 pixel_out,
    output logic                          last_of_item,
    output logic                          end_of_image,
    output logic [dkc_pkg::OUTQ_PTR_W:0]  count
);
    import dkc_pkg::*;

    typedef struct packed {
        pix_t pix;
        logic last;
        logic eoi;
    } entry_t;

    entry_t                mem_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUTQ_PTR_W:0]   count_reg;
    logic [1:0]            push_n;
    logic                  pop;
    entry_t                first_entry, second_entry, head;

    function automatic pix_t clamp_abs(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] mag;
        mag = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
        return (mag > SUM_W'(PIX_MAX)) ? PIX_MAX : mag[PIX_W-1:0];
    endfunction

    always_comb
    begin
        first_entry.pix = clamp_abs(acc.sum0);
        first_entry.last = !acc.two;
        first_entry.eoi = acc.eoi;
        second_entry.pix = clamp_abs(acc.sum1);
        second_entry.last = 1'b1;
        second_entry.eoi = 1'b0;
        push_n = acc.valid ? (acc.two ? 2'd2 : 2'd1) : 2'd0;
        head = mem_reg[rd_ptr_reg];
        result_valid = count_reg != '0;
        pop = result_valid && !result_stall;
        pixel_out = head.pix;
        last_of_item = head.last;
        end_of_image = head.eoi;
        count = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_W'(pop);
            count_reg <= count_reg + (OUTQ_PTR_W + 1)'(push_n) - (OUTQ_PTR_W + 1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc.valid)
        begin
            mem_reg[wr_ptr_reg] <= first_entry;
        end
        if (acc.valid && acc.two)
        begin
            mem_reg[wr_ptr_reg + OUTQ_PTR_W'(1)] <= second_entry;
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    import dkc_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_REQUESTS = 400;

    typedef struct {
        pix_t pixel;
        logic last;
        logic eoi;
    } filter_result_t;

    typedef logic [5:0][ROW_W-1:0] kernel_set_t;

    class filter_scoreboard;
        logic [IMG_W-1:0] size_reg;
        kernel_set_t kernel_rows;
        pix_t two_up [MAX_SIZE];
        pix_t one_up [MAX_SIZE];
        column_t prev_col;
        column_t left_col;
        int unsigned row_pos;
        int unsigned col_pos;
        int unsigned drain_pos;
        filter_result_t expected_pixels [$];
        int unsigned errors;

        function new();
            size_reg = IMAGE_SIZE_RESET;
            kernel_rows = '0;
            foreach (two_up[i])
            begin
                two_up[i] = '0;
                one_up[i] = '0;
            end
            prev_col = '0;
            left_col = '0;
            row_pos = 0;
            col_pos = 0;
            drain_pos = 0;
            errors = 0;
        endfunction

        function void set_register(logic [IDX_W-1:0] idx, logic [ROW_W-1:0] data);
            case (idx)
                REG_IMAGE_SIZE: size_reg = data[IMG_W-1:0];
                REG_K1_TOP:     kernel_rows[0] = data;
                REG_K1_MIDDLE:  kernel_rows[1] = data;
                REG_K1_BOTTOM:  kernel_rows[2] = data;
                REG_K2_TOP:     kernel_rows[3] = data;
                REG_K2_MIDDLE:  kernel_rows[4] = data;
                REG_K2_BOTTOM:  kernel_rows[5] = data;
                default: ;
            endcase
        endfunction

        function int unsigned image_side();
            int unsigned s;
            s = size_reg;
            if (s < MIN_SIZE)
            begin
                s = MIN_SIZE;
            end
            if (s > MAX_SIZE)
            begin
                s = MAX_SIZE;
            end
            return s;
        endfunction

        function int unsigned store_index(int unsigned v);
            return (v < MAX_SIZE) ? v : MAX_SIZE - 1;
        endfunction

        function int weight(int unsigned r, int unsigned c);
            logic signed [KC_W-1:0] a;
            logic signed [KC_W-1:0] b;
            a = kernel_rows[r][KC_W*c +: KC_W];
            b = kernel_rows[r+3][KC_W*c +: KC_W];
            return int'(a) + int'(b);
        endfunction

        function pix_t filter_response(column_t lc, column_t cc, column_t rc);
            window_t win;
            int acc;
            int unsigned r;
            int unsigned c;
            win = {rc, cc, lc};
            acc = 0;
            for (r = 0; r < 3; r++)
            begin
                for (c = 0; c < 3; c++)
                begin
                    acc += weight(r, c) * int'(win[c][r]);
                end
            end
            if (acc < 0)
            begin
                acc = -acc;
            end
            if (acc > int'(PIX_MAX))
            begin
                acc = int'(PIX_MAX);
            end
            return pix_t'(acc);
        endfunction

        function void add_expected(pix_t p, logic last, logic eoi);
            filter_result_t e;
            e.pixel = p;
            e.last = last;
            e.eoi = eoi;
            expected_pixels.push_back(e);
        endfunction

        function void predict_request(logic cmd, pix_t pix);
            int unsigned n;
            int unsigned c;
            int unsigned d;
            int unsigned li;
            int unsigned ri;
            bit last_col;
            bit at_end;
            column_t cur;
            column_t left;
            n = image_side();
            if (cmd == CMD_PIXEL)
            begin
                if (row_pos >= n)
                begin
                    return;
                end
                c = store_index(col_pos);
                last_col = (c >= n - 1);
                cur = {pix, one_up[c], (row_pos >= 2) ? two_up[c] : one_up[c]};
                left = (c >= 2) ? left_col : prev_col;
                if (row_pos >= 1 && c >= 1)
                begin
                    add_expected(filter_response(left, prev_col, cur), !last_col, 1'b0);
                    if (last_col)
                    begin
                        add_expected(filter_response(prev_col, cur, cur), 1'b1, 1'b0);
                    end
                end
                left_col = prev_col;
                prev_col = cur;
                two_up[c] = one_up[c];
                one_up[c] = pix;
                if (last_col)
                begin
                    col_pos = 0;
                    row_pos = (row_pos + 1) % (1 << IMG_W);
                end
                else
                begin
                    col_pos = (c + 1) % (1 << IMG_W);
                end
            end
            else
            begin
                if (row_pos < n)
                begin
                    return;
                end
                d = store_index(drain_pos);
                at_end = (d >= n - 1);
                li = (d >= 1) ? d - 1 : d;
                ri = store_index((d + 1 < n) ? d + 1 : d);
                add_expected(filter_response({one_up[li], one_up[li], two_up[li]},
                                             {one_up[d], one_up[d], two_up[d]},
                                             {one_up[ri], one_up[ri], two_up[ri]}),
                             1'b1, at_end);
                if (at_end)
                begin
                    row_pos = 0;
                    col_pos = 0;
                    drain_pos = 0;
                end
                else
                begin
                    drain_pos = (d + 1) % (1 << IMG_W);
                end
            end
        endfunction

        function void check_result(pix_t pix, logic last, logic eoi);
            filter_result_t e;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: result with none expected, pixel_out %0d last %b eoi %b",
                         $time, pix, last, eoi);
                errors++;
                return;
            end
            e = expected_pixels.pop_front();
            if (pix !== e.pixel)
            begin
                $display("%0t: pixel_out expected %0d, actual %0d", $time, e.pixel, pix);
                errors++;
            end
            if (last !== e.last)
            begin
                $display("%0t: last_of_item expected %b, actual %b", $time, e.last, last);
                errors++;
            end
            if (eoi !== e.eoi)
            begin
                $display("%0t: end_of_image expected %b, actual %b", $time, e.eoi, eoi);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic command;
    pix_t pixel_in;
    logic result_valid;
    logic result_stall;
    pix_t pixel_out;
    logic last_of_item;
    logic end_of_image;
    logic cfg_valid;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0] cfg_data;

    filter_scoreboard sb = new();
    bit send_gaps;
    bit recv_gaps;
    int unsigned long_hold;
    int unsigned quiet_cycles;

    dual_kernel_conv3x3_clamp_top i_dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.set_register(cfg_index, cfg_data);
            end
            if (result_valid === 1'b1 && !result_stall)
            begin
                sb.check_result(pixel_out, last_of_item, end_of_image);
            end
            if (item_valid && item_stall === 1'b0)
            begin
                sb.predict_request(command, pixel_in);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_stall === 1'b0)
            || (result_valid === 1'b1 && !result_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : result_side
        int unsigned hold;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = recv_gaps ? $urandom_range(0, 18) : 0;
            if (long_hold != 0)
            begin
                hold = long_hold;
                long_hold = 0;
            end
            if (hold != 0)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            result_stall <= 1'b0;
            @(posedge clk);
            while (result_valid !== 1'b1) @(posedge clk);
        end
    end

    task automatic send_request(input logic cmd, input pix_t pix);
        int unsigned gap;
        gap = send_gaps ? $urandom_range(0, 18) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        command <= cmd;
        pixel_in <= pix;
        @(posedge clk);
        while (item_stall !== 1'b0) @(posedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_kernels(input kernel_set_t rows);
        write_register(REG_K1_TOP, rows[0]);
        write_register(REG_K1_MIDDLE, rows[1]);
        write_register(REG_K1_BOTTOM, rows[2]);
        write_register(REG_K2_TOP, rows[3]);
        write_register(REG_K2_MIDDLE, rows[4]);
        write_register(REG_K2_BOTTOM, rows[5]);
    endtask

    function automatic logic [ROW_W-1:0] kernel_row();
        logic [ROW_W-1:0] v;
        int unsigned i;
        v = '0;
        case ($urandom_range(0, 5))
            0: v = 24'h7F7F7F;
            1: v = 24'h808080;
            2: v = '0;
            3, 4:
            begin
                for (i = 0; i < 3; i++)
                begin
                    v[KC_W*i +: KC_W] = KC_W'($urandom_range(0, 6) - 3);
                end
            end
            default: v = ROW_W'($urandom());
        endcase
        return v;
    endfunction

    function automatic kernel_set_t random_kernels();
        kernel_set_t rows;
        bit single;
        int unsigned i;
        single = ($urandom_range(0, 3) == 0);
        for (i = 0; i < 6; i++)
        begin
            rows[i] = (single && i >= 3) ? '0 : kernel_row();
        end
        return rows;
    endfunction

    function automatic logic [IMG_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            return IMG_W'($urandom_range(0, 1));
        end
        if (r < 15)
        begin
            return IMG_W'($urandom_range(2, 6));
        end
        if (r < 19)
        begin
            return IMG_W'($urandom_range(7, 12));
        end
        return IMG_W'($urandom_range(16, 20));
    endfunction

    initial
    begin : stimulus
        int unsigned useful;
        int unsigned img;
        int unsigned n;
        int unsigned cut;
        int unsigned k;
        bit broken;
        item_valid = 1'b0;
        command = CMD_PIXEL;
        pixel_in = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_IMAGE_SIZE;
        cfg_data = '0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        long_hold = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset size with an early drain, then the row is cut short by a smaller size.
        send_request(CMD_DRAIN, 8'h00);
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'hA5);
        wait_idle();
        write_register(REG_IMAGE_SIZE, ROW_W'(0));
        write_kernels({24'h0, 24'h0, 24'h0, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F});
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'h5A);
        send_request(CMD_DRAIN, 8'hFF);
        send_request(CMD_DRAIN, 8'h00);

        // Saturated size with most negative weights, shrunk mid-row and mid-drain.
        wait_idle();
        write_register(REG_IMAGE_SIZE, ROW_W'(11'h7FF));
        write_kernels({6{24'h808080}});
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'hFF);
        wait_idle();
        write_register(REG_IMAGE_SIZE, ROW_W'(3));
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_DRAIN, 8'h00);
        wait_idle();
        write_register(REG_IMAGE_SIZE, ROW_W'(2));
        send_request(CMD_DRAIN, 8'hFF);

        useful = 0;
        img = 0;
        while (useful < RANDOM_REQUESTS)
        begin
            if (img == 0 || $urandom_range(0, 9) < 6)
            begin
                wait_idle();
                if (sb.row_pos == 0 && sb.col_pos == 0 && sb.drain_pos == 0)
                begin
                    write_register(REG_IMAGE_SIZE,
                                   ROW_W'((img == 0) ? IMG_W'(10) : pick_size()));
                end
                if (img == 0 || $urandom_range(0, 1) == 0)
                begin
                    write_kernels(random_kernels());
                end
            end
            send_gaps = (img != 0) && ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            if (img == 0)
            begin
                long_hold = LONG_HOLD;
            end
            n = sb.image_side();
            broken = (img != 0) && ($urandom_range(0, 11) == 0);
            cut = broken ? $urandom_range(1, n * n - 1) : n * n;
            for (k = 0; k < cut; k++)
            begin
                if (k + 1 < n * n && $urandom_range(0, 29) == 0)
                begin
                    send_request(CMD_DRAIN, pix_t'($urandom_range(0, 255)));
                end
                send_request(CMD_PIXEL, pix_t'($urandom_range(0, 255)));
                useful++;
            end
            if (broken)
            begin
                repeat ($urandom_range(1, 2)) send_request(CMD_DRAIN, pix_t'($urandom()));
            end
            else
            begin
                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 24) == 0)
                    begin
                        send_request(CMD_PIXEL, pix_t'($urandom_range(0, 255)));
                    end
                    send_request(CMD_DRAIN, pix_t'($urandom_range(0, 255)));
                    useful++;
                end
            end
            img++;
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
